// File: rtl/kwl_pkg.sv
`default_nettype none
package kwl_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [3:0] kind_t;

  localparam kind_t K_IDENT   = 4'd0;
  localparam kind_t K_VAR     = 4'd1;
  localparam kind_t K_FUNC    = 4'd2;
  localparam kind_t K_IF      = 4'd3;
  localparam kind_t K_ELSE    = 4'd4;
  localparam kind_t K_FOR     = 4'd5;
  localparam kind_t K_NUMBER  = 4'd6;
  localparam kind_t K_STRING  = 4'd7;
  localparam kind_t K_OP      = 4'd8;
  localparam kind_t K_LPAREN  = 4'd9;
  localparam kind_t K_RPAREN  = 4'd10;
  localparam kind_t K_LBRACE  = 4'd11;
  localparam kind_t K_RBRACE  = 4'd12;
  localparam kind_t K_SEMI    = 4'd13;
  localparam kind_t K_UNKNOWN = 4'd14;
  localparam kind_t K_EOF     = 4'd15;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             ch;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] length;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic                   last;
  } tok_t;

  // up to two tokens per word, in order
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

endpackage
`default_nettype wire

// File: rtl/kwl_if.sv
`default_nettype none
interface kwl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_end;

  modport source(output valid, output char_code, output is_end, input ready);
  modport sink(input valid, input char_code, input is_end, output ready);
endinterface

interface kwl_tok_if import kwl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [7:0]             token_char;
  logic [OFFSET_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] column_number;
  logic                   last_of_run;

  modport source(output valid, output token_kind, output token_char, output token_start,
                 output token_length, output line_number, output column_number,
                 output last_of_run, input ready);
  modport sink(input valid, input token_kind, input token_char, input token_start,
               input token_length, input line_number, input column_number,
               input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/kwl_front.sv
`default_nettype none
module kwl_front import kwl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  kwl_in_if.sink    src,
  input  wire logic room,
  output push_t     push
);

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_IDENT   = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_STRING  = 6'b001000,
    M_SLASH   = 6'b010000,
    M_COMMENT = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // keyword text, first byte lowest
  localparam logic [31:0] KW_VAR  = 32'h0072_6176;
  localparam logic [31:0] KW_FUNC = 32'h636E_7566;
  localparam logic [31:0] KW_IF   = 32'h0000_6669;
  localparam logic [31:0] KW_ELSE = 32'h6573_6C65;
  localparam logic [31:0] KW_FOR  = 32'h0072_6F66;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h3E, 8'h3C: k = K_OP;
      8'h28: k = K_LPAREN;
      8'h29: k = K_RPAREN;
      8'h7B: k = K_LBRACE;
      8'h7D: k = K_RBRACE;
      8'h3B: k = K_SEMI;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kind_t ident_kind(input logic [31:0] p, input logic [LENGTH_BITS-1:0] n);
    kind_t k;
    k = K_IDENT;
    if (n == LENGTH_BITS'(3) && p == KW_VAR) k = K_VAR;
    else if (n == LENGTH_BITS'(4) && p == KW_FUNC) k = K_FUNC;
    else if (n == LENGTH_BITS'(2) && p == KW_IF) k = K_IF;
    else if (n == LENGTH_BITS'(4) && p == KW_ELSE) k = K_ELSE;
    else if (n == LENGTH_BITS'(3) && p == KW_FOR) k = K_FOR;
    return k;
  endfunction

  mode_t                  mode, mode_next;
  logic [LINE_BITS-1:0]   line, line_next, line_c;
  logic [COLUMN_BITS-1:0] col, col_next, col_c;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [OFFSET_BITS-1:0] ostart, ostart_next;
  logic [LENGTH_BITS-1:0] olen, olen_next, olen_grow;
  logic [31:0]            prefix, prefix_next;
  logic                   saw_end, saw_end_next;

  logic [7:0] c;
  logic       fire;
  logic       flush_en, flush_v, run_idle, sec_v;
  tok_t       flush_t, sec_t;

  assign c    = src.char_code;
  assign fire = src.valid & src.ready;
  assign src.ready = room;

  // position after this byte
  always_comb begin
    if (c == CH_LF) begin
      line_c = (line == LINE_MAX) ? line : line + LINE_BITS'(1);
      col_c  = COLUMN_BITS'(1);
    end else begin
      line_c = line;
      col_c  = (col == COL_MAX) ? col : col + COLUMN_BITS'(1);
    end
    olen_grow = (olen == LEN_MAX) ? olen : olen + LENGTH_BITS'(1);
  end

  // open token, as emitted before this byte is consumed
  always_comb begin
    flush_t        = '0;
    flush_t.start  = ostart;
    flush_t.length = olen;
    flush_t.line   = line;
    flush_t.column = col;
    flush_v        = 1'b0;
    unique case (mode)
      M_IDENT: begin
        flush_t.kind = ident_kind(prefix, olen);
        flush_v      = 1'b1;
      end
      M_NUMBER: begin
        flush_t.kind = K_NUMBER;
        flush_v      = 1'b1;
      end
      M_STRING: begin
        flush_t.kind = K_STRING;
        flush_v      = 1'b1;
      end
      M_SLASH: begin
        flush_t.kind   = K_OP;
        flush_t.ch     = CH_SLASH;
        flush_t.length = LENGTH_BITS'(1);
        flush_v        = 1'b1;
      end
      default: flush_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_next    = mode;
    line_next    = line;
    col_next     = col;
    offset_next  = offset;
    ostart_next  = ostart;
    olen_next    = olen;
    prefix_next  = prefix;
    saw_end_next = saw_end;
    flush_en     = 1'b0;
    run_idle     = 1'b0;
    sec_v        = 1'b0;
    sec_t        = '0;
    sec_t.line   = line_c;
    sec_t.column = col_c;

    if (src.is_end) begin
      flush_en       = !saw_end;
      mode_next      = M_IDLE;
      saw_end_next   = 1'b1;
      sec_v          = 1'b1;
      sec_t.kind     = K_EOF;
      sec_t.start    = offset;
      sec_t.line     = line;
      sec_t.column   = col;
    end else if (!saw_end) begin
      line_next   = line_c;
      col_next    = col_c;
      offset_next = offset + OFFSET_BITS'(1);
      unique case (mode)
        M_STRING: begin
          if (c == CH_QUOTE) begin
            sec_v        = 1'b1;
            sec_t.kind   = K_STRING;
            sec_t.start  = ostart;
            sec_t.length = olen;
            mode_next    = M_IDLE;
          end else begin
            olen_next = olen_grow;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) mode_next = M_IDLE;
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_next = M_COMMENT;
          end else begin
            flush_en = 1'b1;
            run_idle = 1'b1;
          end
        end
        M_IDENT, M_NUMBER: begin
          if (is_digit(c) || (mode == M_IDENT && (is_alpha(c) || c == CH_UNDER))) begin
            unique case (olen)
              LENGTH_BITS'(1): prefix_next = prefix | {16'h0, c, 8'h0};
              LENGTH_BITS'(2): prefix_next = prefix | {8'h0, c, 16'h0};
              LENGTH_BITS'(3): prefix_next = prefix | {c, 24'h0};
              default: prefix_next = prefix;
            endcase
            olen_next = olen_grow;
          end else begin
            flush_en = 1'b1;
            run_idle = 1'b1;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        mode_next = M_IDLE;
        priority if (is_space(c)) begin
          mode_next = M_IDLE;
        end else if (c == CH_SLASH) begin
          ostart_next = offset;
          mode_next   = M_SLASH;
        end else if (is_alpha(c) || c == CH_UNDER || is_digit(c)) begin
          ostart_next = offset;
          olen_next   = LENGTH_BITS'(1);
          prefix_next = {24'h0, c};
          mode_next   = is_digit(c) ? M_NUMBER : M_IDENT;
        end else if (c == CH_QUOTE) begin
          ostart_next = offset + OFFSET_BITS'(1);
          olen_next   = '0;
          mode_next   = M_STRING;
        end else begin
          sec_v        = 1'b1;
          sec_t.kind   = single_kind(c);
          sec_t.ch     = c;
          sec_t.start  = offset;
          sec_t.length = LENGTH_BITS'(1);
        end
      end
    end
  end

  // pack into queue push, mark last of run
  always_comb begin
    push = '0;
    if (flush_en && flush_v) begin
      push.t0      = flush_t;
      push.t1      = sec_t;
      push.t0.last = !sec_v;
      push.t1.last = 1'b1;
      push.n       = sec_v ? 2'd2 : 2'd1;
    end else begin
      push.t0      = sec_t;
      push.t0.last = 1'b1;
      push.n       = sec_v ? 2'd1 : 2'd0;
    end
    if (!fire) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      line    <= LINE_BITS'(1);
      col     <= COLUMN_BITS'(1);
      offset  <= '0;
      ostart  <= '0;
      olen    <= '0;
      prefix  <= '0;
      saw_end <= 1'b0;
    end else if (fire) begin
      mode    <= mode_next;
      line    <= line_next;
      col     <= col_next;
      offset  <= offset_next;
      ostart  <= ostart_next;
      olen    <= olen_next;
      prefix  <= prefix_next;
      saw_end <= saw_end_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/kwl_queue.sv
`default_nettype none
module kwl_queue import kwl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  push_t     push,
  output logic      room,
  kwl_tok_if.source tok
);

  tok_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wptr, rptr;
  logic [QCNT_W-1:0]  count, count_next;
  logic               pop;
  tok_t               head;

  assign head = mem[rptr];
  assign pop  = tok.valid & tok.ready;
  assign room = count <= QCNT_W'(QDEPTH - 2);

  assign tok.valid         = count != '0;
  assign tok.token_kind    = head.kind;
  assign tok.token_char    = head.ch;
  assign tok.token_start   = head.start;
  assign tok.token_length  = head.length;
  assign tok.line_number   = head.line;
  assign tok.column_number = head.column;
  assign tok.last_of_run   = head.last;

  assign count_next = count + QCNT_W'(push.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wptr] <= push.t0;
    if (push.n == 2'd2) mem[wptr + QPTR_W'(1)] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push.n);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/keyword_token_lexer.sv
`default_nettype none
// Byte-serial lexer: takes one source byte (or an end marker) per cycle and
// emits zero, one or two tokens for it, one token word per cycle on the output.
// A byte is taken in the cycle it arrives whenever the four-entry token queue
// between the scanner and the output has at least two free slots; with at most
// one token per byte on average and a ready receiver the input runs at one byte
// per clock, and a byte that closes an open token and is a token itself yields two.
// The queue head drives the output directly from registers.
module keyword_token_lexer import kwl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  kwl_in_if.sink    src,
  kwl_tok_if.source tok
);

  push_t push;
  logic  room;

  kwl_front u_front (
    .clk  (clk),
    .rst  (rst),
    .src  (src),
    .room (room),
    .push (push)
  );

  kwl_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .tok  (tok)
  );

endmodule
`default_nettype wire

// File: tb/keyword_token_lexer_tb.sv
module keyword_token_lexer_tb;
  import kwl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_SLASH,
    SCAN_COMMENT
  } scan_t;

  // identifier prefix keeps the first byte lowest, so the literals read backwards
  localparam logic [31:0] KW_VAR  = {8'h00, "rav"};
  localparam logic [31:0] KW_FUNC = "cnuf";
  localparam logic [31:0] KW_IF   = {16'h0000, "fi"};
  localparam logic [31:0] KW_ELSE = "esle";
  localparam logic [31:0] KW_FOR  = {8'h00, "rof"};

  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_BYTES = 1800;
  localparam int HOLD_CYCLES  = 100;

  logic clk = 1'b0;
  logic rst;

  kwl_in_if  src_bus();
  kwl_tok_if tok_bus();

  keyword_token_lexer u_top (
    .clk(clk),
    .rst(rst),
    .src(src_bus),
    .tok(tok_bus)
  );

  class token_scoreboard;
    scan_t                  mode;
    logic [LINE_BITS-1:0]   line_cnt;
    logic [COLUMN_BITS-1:0] col_cnt;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [LENGTH_BITS-1:0] tok_len;
    logic [31:0]            prefix;
    bit                     ended;
    tok_t                   step_out[$];
    tok_t                   expected_tokens[$];
    int                     errors;
    int                     checked;

    function new();
      mode      = SCAN_IDLE;
      line_cnt  = LINE_BITS'(1);
      col_cnt   = COLUMN_BITS'(1);
      offset    = '0;
      tok_start = '0;
      tok_len   = '0;
      prefix    = '0;
      ended     = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void consume(logic [7:0] c);
      offset = offset + 1'b1;
      if (c == 8'h0a) begin
        if (line_cnt != '1) line_cnt++;
        col_cnt = COLUMN_BITS'(1);
      end else if (col_cnt != '1) begin
        col_cnt++;
      end
    endfunction

    function void grow();
      if (tok_len != '1) tok_len++;
    endfunction

    function void emit(kind_t k, logic [7:0] ch, logic [OFFSET_BITS-1:0] st,
                       logic [LENGTH_BITS-1:0] len);
      tok_t t;
      t.kind   = k;
      t.ch     = ch;
      t.start  = st;
      t.length = len;
      t.line   = line_cnt;
      t.column = col_cnt;
      t.last   = 1'b0;
      step_out.push_back(t);
    endfunction

    function kind_t ident_kind();
      if (tok_len == 3 && prefix == KW_VAR)  return K_VAR;
      if (tok_len == 4 && prefix == KW_FUNC) return K_FUNC;
      if (tok_len == 2 && prefix == KW_IF)   return K_IF;
      if (tok_len == 4 && prefix == KW_ELSE) return K_ELSE;
      if (tok_len == 3 && prefix == KW_FOR)  return K_FOR;
      return K_IDENT;
    endfunction

    function void flush_open();
      case (mode)
        SCAN_IDENT:  emit(ident_kind(), 8'h00, tok_start, tok_len);
        SCAN_NUMBER: emit(K_NUMBER, 8'h00, tok_start, tok_len);
        SCAN_STRING: emit(K_STRING, 8'h00, tok_start, tok_len);
        SCAN_SLASH:  emit(K_OP, "/", tok_start, LENGTH_BITS'(1));
        default: ;
      endcase
      mode = SCAN_IDLE;
    endfunction

    function void lex_idle(logic [7:0] c);
      logic [OFFSET_BITS-1:0] here;
      kind_t                  k;
      here = offset;
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
        consume(c);
      end else if (c == "/") begin
        tok_start = here;
        consume(c);
        mode = SCAN_SLASH;
      end else if (is_alpha(c) || c == "_" || is_digit(c)) begin
        tok_start = here;
        tok_len   = LENGTH_BITS'(1);
        prefix    = {24'h0, c};
        consume(c);
        mode = is_digit(c) ? SCAN_NUMBER : SCAN_IDENT;
      end else if (c == "\"") begin
        consume(c);
        tok_start = offset;
        tok_len   = '0;
        mode      = SCAN_STRING;
      end else begin
        case (c)
          "=", "+", "-", "*", ">", "<": k = K_OP;
          "(": k = K_LPAREN;
          ")": k = K_RPAREN;
          "{": k = K_LBRACE;
          "}": k = K_RBRACE;
          ";": k = K_SEMI;
          default: k = K_UNKNOWN;
        endcase
        consume(c);
        emit(k, c, here, LENGTH_BITS'(1));
      end
    endfunction

    function void note_byte(logic [7:0] c, logic is_end);
      step_out.delete();
      if (is_end) begin
        if (!ended) flush_open();
        ended = 1'b1;
        emit(K_EOF, 8'h00, offset, '0);
      end else if (!ended) begin
        case (mode)
          SCAN_STRING: begin
            consume(c);
            if (c == "\"") begin
              emit(K_STRING, 8'h00, tok_start, tok_len);
              mode = SCAN_IDLE;
            end else begin
              grow();
            end
          end
          SCAN_COMMENT: begin
            consume(c);
            if (c == 8'h0a) mode = SCAN_IDLE;
          end
          SCAN_SLASH: begin
            if (c == "/") begin
              consume(c);
              mode = SCAN_COMMENT;
            end else begin
              flush_open();
              lex_idle(c);
            end
          end
          SCAN_IDENT, SCAN_NUMBER: begin
            if (is_digit(c) || (mode == SCAN_IDENT && (is_alpha(c) || c == "_"))) begin
              if (tok_len < 4) prefix[8*int'(tok_len) +: 8] = c;
              grow();
              consume(c);
            end else begin
              flush_open();
              lex_idle(c);
            end
          end
          default: begin
            mode = SCAN_IDLE;
            lex_idle(c);
          end
        endcase
      end
      if (step_out.size() != 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
    endfunction

    task check_token(tok_t got);
      tok_t  want;
      string bad;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token with nothing expected: kind %0d start %0d",
                         got.kind, got.start));
        return;
      end
      want = expected_tokens.pop_front();
      bad  = "";
      if (got.kind   !== want.kind)   bad = {bad, " kind"};
      if (got.ch     !== want.ch)     bad = {bad, " char"};
      if (got.start  !== want.start)  bad = {bad, " start"};
      if (got.length !== want.length) bad = {bad, " length"};
      if (got.line   !== want.line)   bad = {bad, " line"};
      if (got.column !== want.column) bad = {bad, " column"};
      if (got.last   !== want.last)   bad = {bad, " last"};
      if (bad != "") begin
        report($sformatf("token %0d wrong%s: got %0d %h %0d %0d %0d %0d %b, want %0d %h %0d %0d %0d %0d %b",
                         checked, bad, got.kind, got.ch, got.start, got.length, got.line,
                         got.column, got.last, want.kind, want.ch, want.start, want.length,
                         want.line, want.column, want.last));
      end
      checked++;
    endtask
  endclass

  token_scoreboard sb;
  logic [8:0]      source_words[$];
  int              words_taken = 0;
  string           keywords[5] = '{"var", "func", "if", "else", "for"};
  string           single_chars = "=+-*><(){};";

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function void push_text(string s);
    foreach (s[i]) source_words.push_back({1'b0, s[i]});
  endfunction

  function void push_char(logic [7:0] c);
    source_words.push_back({1'b0, c});
  endfunction

  function logic [7:0] space_char();
    logic [7:0] pick;
    pick = 8'($urandom_range(0, 5));
    return (pick == 0) ? 8'h20 : 8'h08 + pick;
  endfunction

  function logic [7:0] word_char(bit lead);
    int pick;
    pick = $urandom_range(lead ? 10 : 0, 62);
    if (pick < 10) return 8'("0" + pick);
    if (pick < 36) return 8'("a" + (pick - 10));
    if (pick < 62) return 8'("A" + (pick - 36));
    return "_";
  endfunction

  function void add_fragment();
    string kw;
    int    n;
    logic [7:0] c;
    case ($urandom_range(0, 13))
      0, 1: push_text(keywords[$urandom_range(0, 4)]);
      2: begin
        // near misses around keywords
        kw = keywords[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) begin
          push_text(kw.substr(0, kw.len() - 2));
        end else begin
          push_text(kw);
          repeat ($urandom_range(1, 3)) push_char(word_char(1'b0));
        end
      end
      3, 4: begin
        push_char(word_char(1'b1));
        repeat ($urandom_range(0, 7)) push_char(word_char(1'b0));
      end
      5: repeat ($urandom_range(1, 6)) push_char(8'("0" + $urandom_range(0, 9)));
      6: begin
        push_char("\"");
        n = $urandom_range(0, 8);
        repeat (n) begin
          c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(32, 126));
          if (c == "\"") c = "x";
          push_char(c);
        end
        push_char("\"");
      end
      7: begin
        push_text("//");
        repeat ($urandom_range(0, 10)) begin
          c = 8'($urandom_range(0, 255));
          if (c == 8'h0a) c = "/";
          push_char(c);
        end
        push_char(8'h0a);
      end
      8, 9: push_char(single_chars[$urandom_range(0, single_chars.len() - 1)]);
      10: push_char("/");
      11: repeat ($urandom_range(1, 3)) push_char(space_char());
      default: push_char(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1)) push_char(space_char());
  endfunction

  task send_word(logic [8:0] w);
    src_bus.valid     <= 1'b1;
    src_bus.is_end    <= w[8];
    src_bus.char_code <= w[7:0];
    do @(posedge clk); while (src_bus.ready !== 1'b1);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    tok_t seen;
    if (!rst) begin
      if (tok_bus.valid === 1'b1 && tok_bus.ready === 1'b1) begin
        seen.kind   = tok_bus.token_kind;
        seen.ch     = tok_bus.token_char;
        seen.start  = tok_bus.token_start;
        seen.length = tok_bus.token_length;
        seen.line   = tok_bus.line_number;
        seen.column = tok_bus.column_number;
        seen.last   = tok_bus.last_of_run;
        sb.check_token(seen);
      end
      if (src_bus.valid === 1'b1 && src_bus.ready === 1'b1) begin
        sb.note_byte(src_bus.char_code, src_bus.is_end);
        words_taken++;
      end
    end
  end

  // receiver: rotating stall patterns plus one long hold-off mid-run
  initial begin
    int  cyc;
    bit  held;
    cyc  = 0;
    held = 1'b0;
    tok_bus.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && words_taken >= 700) begin
        tok_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        case ((cyc / 150) % 4)
          0: tok_bus.ready <= 1'b1;
          1: tok_bus.ready <= 1'($urandom_range(0, 1));
          2: tok_bus.ready <= (cyc % 4 == 0);
          default: tok_bus.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int burst;
    int gap;
    sb = new();
    rst = 1'b1;
    src_bus.valid     = 1'b0;
    src_bus.char_code = 8'h00;
    src_bus.is_end    = 1'b0;

    // directed text: every keyword, bracket kind, an empty string, slash then bracket,
    // a comment, and the extreme byte values
    push_text("var-func(if}else{for;7*\"\"/)//\n");
    push_char(8'h00);
    push_char(8'hff);
    while (source_words.size() < RANDOM_BYTES) add_fragment();

    // open token at the end marker
    case ($urandom_range(0, 5))
      0: push_text(keywords[$urandom_range(0, 4)]);
      1: push_text("42");
      2: push_text("\"ab");
      3: push_text("/");
      4: push_text("//x");
      default: ;
    endcase
    source_words.push_back({1'b1, 8'($urandom_range(0, 255))});
    repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
    source_words.push_back({1'b1, 8'($urandom_range(0, 255))});

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    burst = $urandom_range(1, 24);
    foreach (source_words[i]) begin
      if (burst == 0) begin
        src_bus.valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(negedge clk);
        burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      send_word(source_words[i]);
      burst--;
    end
    src_bus.valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
